### design/sor_pkg.sv
package sor_pkg;

	// Pool geometry.
	localparam int SLAB_MAX = 16;
	localparam int OBJ_MAX  = 64;
	localparam int SLAB_W   = $clog2(SLAB_MAX);
	localparam int SLOT_W   = $clog2(OBJ_MAX);
	localparam int SLINK_W  = $clog2(SLAB_MAX + 1);
	localparam int OLINK_W  = $clog2(OBJ_MAX + 1);
	localparam int FC_W     = 7;
	localparam int FC_MAX   = 127;
	localparam int OBJ_ADDR_W = SLAB_W + SLOT_W;

	// Register widths and limits.
	localparam int OPS_W    = 7;
	localparam int LIM_W    = 5;
	localparam int BPS_W    = 9;
	localparam int BPS_MAX  = 256;
	localparam int FREED_W  = 13;
	localparam int FREED_MAX = 8191;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [1:0] {
		TAG_UNUSED  = 2'd0,
		TAG_EMPTY   = 2'd1,
		TAG_PARTIAL = 2'd2,
		TAG_FULL    = 2'd3
	} tag_t;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_SHRINK = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBJS_PER_SLAB  = 2'd0,
		CFG_SLAB_LIMIT     = 2'd1,
		CFG_BLOCKS_PER_SLAB = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [SLAB_W-1:0] slab_index;
		logic [SLOT_W-1:0] object_slot;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLAB_W-1:0]  alloc_slab;
		logic [SLOT_W-1:0]  alloc_slot;
		logic [FREED_W-1:0] blocks_freed;
	} out_item_t;

	// One word of the object memory: occupancy and free chain link.
	typedef struct packed {
		logic               occ;
		logic [OLINK_W-1:0] nxt;
	} obj_word_t;

	localparam int OBJ_WORD_W = $bits(obj_word_t);

endpackage

### design/sor_ram.sv
module sor_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/slab_object_allocator_unit.sv
// Slab object allocator for one object cache.
// Input channel (in_valid, in_stall, in_data): one item is an operation:
// allocate an object, free the object (slab_index, object_slot), or shrink.
// Output channel (out_valid, out_stall, out_data): exactly one result item
// per input item, in order, held in an output register until taken.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 objects
// per slab, 1 slab limit, 2 blocks per slab); write only while idle.
// A sequencer works one item at a time around an object memory with a
// registered read. An alloc from a new slab first sweeps the slab to
// build its slot chain; shrink releases the empty slabs one after another
// unless it is blocked.
// The result is written to the output register at the end; a new item is
// taken in the cycle after, even while that result still waits.
// When the receiver stalls, the finished result stays in the output
// register and a further finished result waits in the sequencer.
// Reset empties all lists and clears the slab count; the object memory
// needs no clearing, since each slab is swept when it is created.
module slab_object_allocator_unit
	import sor_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SWEEP,
		S_POP_RD,
		S_POP_WR,
		S_UNL1,
		S_UNL2,
		S_PUSH1,
		S_PUSH2,
		S_FREE_CHK,
		S_SHRINK,
		S_FINISH
	} state_t;

	localparam logic [SLINK_W-1:0] SNIL = SLINK_W'(SLAB_MAX);
	localparam logic [OLINK_W-1:0] ONIL = OLINK_W'(OBJ_MAX);

	state_t state_q;
	in_item_t in_q;

	// Configuration registers.
	logic [OPS_W-1:0] ops_q;
	logic [LIM_W-1:0] lim_q;
	logic [BPS_W-1:0] bps_q;

	// Slab table.
	tag_t               tag_q   [SLAB_MAX];
	logic [SLINK_W-1:0] next_q  [SLAB_MAX];
	logic [SLINK_W-1:0] prev_q  [SLAB_MAX];
	logic [FC_W-1:0]    fc_q    [SLAB_MAX];
	logic [OLINK_W-1:0] chead_q [SLAB_MAX];
	logic [SLINK_W-1:0] heads_q [4];
	logic               shrink_ok_q;
	logic [SLINK_W-1:0] slabs_q;

	// Working registers of the sequencer.
	logic [SLAB_W-1:0]  s_q;
	logic [SLOT_W-1:0]  slot_q;
	tag_t               tgt_q;
	tag_t               cur_tag_q;
	logic [SLINK_W-1:0] n_q;
	logic [SLINK_W-1:0] p_q;
	logic [SLINK_W-1:0] h_q;
	logic [OLINK_W-1:0] cnt_q;
	logic               src_part_q;
	logic               then_pop_q;
	logic [1:0]         status_q;
	logic [SLAB_W-1:0]  res_slab_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [FREED_W-1:0] freed_q;

	logic      out_valid_q;
	out_item_t out_q;

	// Object memory port.
	logic                  ram_we;
	logic [OBJ_ADDR_W-1:0] ram_waddr;
	obj_word_t             ram_wdata;
	logic [OBJ_ADDR_W-1:0] ram_raddr;
	obj_word_t             ram_rdata;

	// Effective register values.
	logic [OPS_W-1:0]     opc;
	logic [LIM_W-1:0]     lim;
	logic [BPS_W-1:0]     bps;
	logic [FREED_W:0]     freed_sum;
	logic [SLOT_W-1:0]    pop_h;
	logic [FC_W-1:0]      fc_dec;
	logic [FC_W-1:0]      fc_inc;
	logic [OLINK_W-1:0]   sweep_next;
	logic                 found;
	logic [SLAB_W-1:0]    free_slab;

	always_comb begin
		if (ops_q == '0) begin
			opc = OPS_W'(1);
		end else if (ops_q > OPS_W'(OBJ_MAX)) begin
			opc = OPS_W'(OBJ_MAX);
		end else begin
			opc = ops_q;
		end
		lim = (lim_q > LIM_W'(SLAB_MAX)) ? LIM_W'(SLAB_MAX) : lim_q;
		if (bps_q == '0) begin
			bps = BPS_W'(1);
		end else if (bps_q > BPS_W'(BPS_MAX)) begin
			bps = BPS_W'(BPS_MAX);
		end else begin
			bps = bps_q;
		end
	end

	// Small arithmetic shared by the steps.
	always_comb begin
		freed_sum = {1'b0, freed_q} + (FREED_W + 1)'(bps);
		pop_h = (chead_q[s_q] >= ONIL) ? '0 : chead_q[s_q][SLOT_W-1:0];
		fc_dec = (fc_q[s_q] != '0) ? fc_q[s_q] - FC_W'(1) : '0;
		fc_inc = (fc_q[s_q] == FC_W'(FC_MAX)) ? fc_q[s_q] : fc_q[s_q] + FC_W'(1);
		sweep_next = (OPS_W'(cnt_q) + OPS_W'(1) < opc) ? cnt_q + OLINK_W'(1) : ONIL;
	end

	// Lowest unused slab slot.
	always_comb begin
		found = 1'b0;
		free_slab = '0;
		for (int i = SLAB_MAX - 1; i >= 0; i--) begin
			if (tag_q[i] == TAG_UNUSED) begin
				found = 1'b1;
				free_slab = SLAB_W'(i);
			end
		end
	end

	// Object memory addressing per step.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = {s_q, slot_q};
		ram_wdata = '0;
		ram_raddr = {s_q, pop_h};
		case (state_q)
			S_DISPATCH: begin
				ram_raddr = {in_q.slab_index, in_q.object_slot};
			end
			S_SWEEP: begin
				ram_we = 1'b1;
				ram_waddr = {s_q, cnt_q[SLOT_W-1:0]};
				ram_wdata = '{occ: 1'b0, nxt: sweep_next};
			end
			S_POP_WR: begin
				ram_we = 1'b1;
				ram_wdata = '{occ: 1'b1, nxt: ram_rdata.nxt};
			end
			S_FREE_CHK: begin
				ram_we = ram_rdata.occ;
				ram_wdata = '{occ: 1'b0, nxt: chead_q[s_q]};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	sor_ram #(
		.WIDTH(OBJ_WORD_W),
		.DEPTH(SLAB_MAX * OBJ_MAX)
	) u_obj_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, slab table and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ops_q <= OPS_W'(OBJ_MAX);
			lim_q <= LIM_W'(SLAB_MAX);
			bps_q <= BPS_W'(1);
			for (int i = 0; i < SLAB_MAX; i++) begin
				tag_q[i] <= TAG_UNUSED;
			end
			for (int i = 0; i < 4; i++) begin
				heads_q[i] <= SNIL;
			end
			shrink_ok_q <= 1'b1;
			slabs_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OBJS_PER_SLAB:   ops_q <= cfg_data[OPS_W-1:0];
					CFG_SLAB_LIMIT:      lim_q <= cfg_data[LIM_W-1:0];
					CFG_BLOCKS_PER_SLAB: bps_q <= cfg_data[BPS_W-1:0];
					default: ;
				endcase
			end

			// The output register fills when an item finishes and empties when taken.
			if (state_q == S_FINISH && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						state_q <= S_DISPATCH;
					end
				end

				S_DISPATCH: begin
					status_q <= ST_OK;
					res_slab_q <= '0;
					res_slot_q <= '0;
					freed_q <= '0;
					src_part_q <= 1'b0;
					then_pop_q <= 1'b0;
					case (in_q.operation)
						OP_ALLOC: begin
							if (heads_q[TAG_PARTIAL] < SNIL) begin
								s_q <= heads_q[TAG_PARTIAL][SLAB_W-1:0];
								src_part_q <= 1'b1;
								state_q <= S_POP_RD;
							end else if (heads_q[TAG_EMPTY] < SNIL) begin
								s_q <= heads_q[TAG_EMPTY][SLAB_W-1:0];
								then_pop_q <= 1'b1;
								state_q <= S_UNL1;
							end else if (found && (LIM_W'(slabs_q) < lim)) begin
								s_q <= free_slab;
								cnt_q <= '0;
								state_q <= S_SWEEP;
							end else begin
								status_q <= ST_NO_SPACE;
								state_q <= S_FINISH;
							end
						end
						OP_FREE: begin
							s_q <= in_q.slab_index;
							slot_q <= in_q.object_slot;
							cur_tag_q <= tag_q[in_q.slab_index];
							if ((tag_q[in_q.slab_index] != TAG_PARTIAL &&
							     tag_q[in_q.slab_index] != TAG_FULL) ||
							    (OPS_W'(in_q.object_slot) >= opc)) begin
								status_q <= ST_INVALID;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_FREE_CHK;
							end
						end
						OP_SHRINK: begin
							if (!shrink_ok_q) begin
								shrink_ok_q <= 1'b1;
								state_q <= S_FINISH;
							end else begin
								n_q <= heads_q[TAG_EMPTY];
								cnt_q <= '0;
								state_q <= S_SHRINK;
							end
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end

				// Build the ascending free chain of a new slab.
				S_SWEEP: begin
					cnt_q <= cnt_q + OLINK_W'(1);
					if (cnt_q == OLINK_W'(OBJ_MAX - 1)) begin
						chead_q[s_q] <= '0;
						fc_q[s_q] <= FC_W'(opc);
						slabs_q <= slabs_q + SLINK_W'(1);
						shrink_ok_q <= 1'b0;
						state_q <= S_POP_RD;
					end
				end

				S_POP_RD: begin
					slot_q <= pop_h;
					state_q <= S_POP_WR;
				end

				// Take the chain head and decide where the slab goes.
				S_POP_WR: begin
					chead_q[s_q] <= ram_rdata.nxt;
					fc_q[s_q] <= fc_dec;
					res_slab_q <= s_q;
					res_slot_q <= slot_q;
					then_pop_q <= 1'b0;
					if (src_part_q) begin
						if (fc_dec == '0) begin
							tgt_q <= TAG_FULL;
							state_q <= S_UNL1;
						end else begin
							state_q <= S_FINISH;
						end
					end else begin
						tgt_q <= (fc_dec == '0) ? TAG_FULL : TAG_PARTIAL;
						state_q <= S_PUSH1;
					end
				end

				// Unlink: first fix the successor, then the predecessor or head.
				S_UNL1: begin
					n_q <= next_q[s_q];
					p_q <= prev_q[s_q];
					cur_tag_q <= tag_q[s_q];
					if (next_q[s_q] < SNIL) begin
						prev_q[next_q[s_q][SLAB_W-1:0]] <= prev_q[s_q];
					end
					state_q <= S_UNL2;
				end

				S_UNL2: begin
					if (p_q < SNIL) begin
						next_q[p_q[SLAB_W-1:0]] <= n_q;
					end else begin
						heads_q[cur_tag_q] <= n_q;
					end
					state_q <= then_pop_q ? S_POP_RD : S_PUSH1;
				end

				// Push at the head of the target list.
				S_PUSH1: begin
					h_q <= heads_q[tgt_q];
					next_q[s_q] <= heads_q[tgt_q];
					prev_q[s_q] <= SNIL;
					heads_q[tgt_q] <= {1'b0, s_q};
					tag_q[s_q] <= tgt_q;
					state_q <= S_PUSH2;
				end

				S_PUSH2: begin
					if (h_q < SNIL) begin
						prev_q[h_q[SLAB_W-1:0]] <= {1'b0, s_q};
					end
					state_q <= S_FINISH;
				end

				// The slot must be occupied; then chain it and count it free.
				S_FREE_CHK: begin
					if (!ram_rdata.occ) begin
						status_q <= ST_INVALID;
						state_q <= S_FINISH;
					end else begin
						chead_q[s_q] <= {1'b0, slot_q};
						fc_q[s_q] <= fc_inc;
						if (OPS_W'(fc_inc) >= opc) begin
							tgt_q <= TAG_EMPTY;
							state_q <= S_UNL1;
						end else if (cur_tag_q == TAG_FULL) begin
							tgt_q <= TAG_PARTIAL;
							state_q <= S_UNL1;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end

				// Release one empty slab per cycle.
				S_SHRINK: begin
					if ((n_q < SNIL) && (cnt_q < OLINK_W'(SLAB_MAX))) begin
						n_q <= next_q[n_q[SLAB_W-1:0]];
						tag_q[n_q[SLAB_W-1:0]] <= TAG_UNUSED;
						next_q[n_q[SLAB_W-1:0]] <= SNIL;
						prev_q[n_q[SLAB_W-1:0]] <= SNIL;
						if (slabs_q != '0) begin
							slabs_q <= slabs_q - SLINK_W'(1);
						end
						freed_q <= (freed_sum > (FREED_W + 1)'(FREED_MAX)) ?
							FREED_W'(FREED_MAX) : freed_sum[FREED_W-1:0];
						cnt_q <= cnt_q + OLINK_W'(1);
					end else begin
						heads_q[TAG_EMPTY] <= SNIL;
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_q <= '{status: status_q, alloc_slab: res_slab_q,
							alloc_slot: res_slot_q, blocks_freed: freed_q};
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The slab count never passes the pool size.
	a_slabs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slabs_q <= SLINK_W'(SLAB_MAX))
		else $error("slab count above pool size");

	// Between items, the partial and empty list heads each point at a slab carrying that list's tag.
	a_partial_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && heads_q[TAG_PARTIAL] < SNIL) |->
		tag_q[heads_q[TAG_PARTIAL][SLAB_W-1:0]] == TAG_PARTIAL)
		else $error("partial head has wrong tag");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && heads_q[TAG_EMPTY] < SNIL) |->
		tag_q[heads_q[TAG_EMPTY][SLAB_W-1:0]] == TAG_EMPTY)
		else $error("empty head has wrong tag");

	// A result appears only when the sequencer finishes an item.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result without finished item");

endmodule

### sim/slab_object_allocator_unit_tb.sv
module slab_object_allocator_unit_tb
	import sor_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the allocator state and predicts the result of every operation.
	class alloc_scoreboard;
		logic [6:0] objs_cfg;
		logic [4:0] limit_cfg;
		logic [8:0] blocks_cfg;
		logic [1:0] tag [SLAB_MAX];
		int nxt_link [SLAB_MAX];
		int prv_link [SLAB_MAX];
		int head [4];
		int fcount [SLAB_MAX];
		int chain_head [SLAB_MAX];
		int obj_link [SLAB_MAX*OBJ_MAX];
		bit occ [SLAB_MAX*OBJ_MAX];
		bit shrink_ok;
		int in_use;
		out_item_t pending [$];
		int errors;

		function new();
			objs_cfg = 64;
			limit_cfg = 16;
			blocks_cfg = 1;
			foreach (tag[i]) begin
				tag[i] = TAG_UNUSED;
				nxt_link[i] = SLAB_MAX;
				prv_link[i] = SLAB_MAX;
				fcount[i] = 0;
				chain_head[i] = 0;
			end
			foreach (head[i]) head[i] = SLAB_MAX;
			foreach (obj_link[i]) begin
				obj_link[i] = 0;
				occ[i] = 0;
			end
			shrink_ok = 1;
			in_use = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [8:0] val);
			case (idx)
				CFG_OBJS_PER_SLAB: objs_cfg = val[6:0];
				CFG_SLAB_LIMIT: limit_cfg = val[4:0];
				CFG_BLOCKS_PER_SLAB: blocks_cfg = val;
				default: ;
			endcase
		endfunction

		function void unlink(int s);
			int n, p;
			n = nxt_link[s];
			p = prv_link[s];
			if (n < SLAB_MAX) prv_link[n] = p;
			if (p < SLAB_MAX) nxt_link[p] = n;
			else head[tag[s]] = n;
			nxt_link[s] = SLAB_MAX;
			prv_link[s] = SLAB_MAX;
		endfunction

		function void push(int s, tag_t t);
			int h;
			h = head[t];
			nxt_link[s] = h;
			prv_link[s] = SLAB_MAX;
			if (h < SLAB_MAX) prv_link[h] = s;
			head[t] = s;
			tag[s] = t;
		endfunction

		function int take_slot(int s);
			int h;
			h = chain_head[s];
			if (h >= OBJ_MAX) h = 0;
			chain_head[s] = obj_link[s*OBJ_MAX + h];
			if (fcount[s] > 0) fcount[s]--;
			occ[s*OBJ_MAX + h] = 1;
			return h;
		endfunction

		// Notes one accepted operation and queues its expected result.
		function void note_input(in_item_t it);
			int opc, lim, s, bps, freed, n, sl;
			logic [1:0] t;
			out_item_t r;
			r = '0;
			opc = objs_cfg < 1 ? 1 : (objs_cfg > OBJ_MAX ? OBJ_MAX : objs_cfg);
			case (op_t'(it.operation))
				OP_ALLOC: begin
					s = head[TAG_PARTIAL];
					if (s < SLAB_MAX) begin
						r.alloc_slab = SLAB_W'(s);
						r.alloc_slot = SLOT_W'(take_slot(s));
						if (fcount[s] == 0) begin
							unlink(s);
							push(s, TAG_FULL);
						end
					end else begin
						lim = limit_cfg > SLAB_MAX ? SLAB_MAX : limit_cfg;
						s = head[TAG_EMPTY];
						if (s < SLAB_MAX) unlink(s);
						else begin
							s = SLAB_MAX;
							if (in_use < lim)
								for (int i = SLAB_MAX - 1; i >= 0; i--)
									if (tag[i] == TAG_UNUSED) s = i;
							if (s < SLAB_MAX) begin
								for (int i = 0; i < OBJ_MAX; i++) begin
									occ[s*OBJ_MAX + i] = 0;
									obj_link[s*OBJ_MAX + i] = (i + 1 < opc) ? i + 1 : OBJ_MAX;
								end
								chain_head[s] = 0;
								fcount[s] = opc;
								nxt_link[s] = SLAB_MAX;
								prv_link[s] = SLAB_MAX;
								in_use++;
								shrink_ok = 0;
							end
						end
						if (s < SLAB_MAX) begin
							r.alloc_slab = SLAB_W'(s);
							r.alloc_slot = SLOT_W'(take_slot(s));
							push(s, tag_t'(fcount[s] == 0 ? TAG_FULL : TAG_PARTIAL));
						end else r.status = ST_NO_SPACE;
					end
				end
				OP_FREE: begin
					s = int'(it.slab_index);
					sl = int'(it.object_slot);
					t = tag[s];
					if ((t != TAG_PARTIAL && t != TAG_FULL) || sl >= opc || !occ[s*OBJ_MAX + sl])
						r.status = ST_INVALID;
					else begin
						obj_link[s*OBJ_MAX + sl] = chain_head[s];
						chain_head[s] = sl;
						if (fcount[s] < FC_MAX) fcount[s]++;
						occ[s*OBJ_MAX + sl] = 0;
						if (fcount[s] >= opc) begin
							unlink(s);
							push(s, TAG_EMPTY);
						end else if (t == TAG_FULL) begin
							unlink(s);
							push(s, TAG_PARTIAL);
						end
					end
				end
				OP_SHRINK: begin
					if (!shrink_ok) shrink_ok = 1;
					else begin
						bps = blocks_cfg < 1 ? 1 : (blocks_cfg > BPS_MAX ? BPS_MAX : blocks_cfg);
						freed = 0;
						s = head[TAG_EMPTY];
						for (int g = 0; g < SLAB_MAX && s < SLAB_MAX; g++) begin
							n = nxt_link[s];
							tag[s] = TAG_UNUSED;
							nxt_link[s] = SLAB_MAX;
							prv_link[s] = SLAB_MAX;
							if (in_use > 0) in_use--;
							freed += bps;
							if (freed > FREED_MAX) freed = FREED_MAX;
							s = n;
						end
						head[TAG_EMPTY] = SLAB_MAX;
						r.blocks_freed = FREED_W'(freed);
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		// Compares one accepted result with the oldest expected result.
		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.alloc_slab !== want.alloc_slab)
					report("alloc_slab", got.alloc_slab, want.alloc_slab);
				if (got.alloc_slot !== want.alloc_slot)
					report("alloc_slot", got.alloc_slot, want.alloc_slot);
				if (got.blocks_freed !== want.blocks_freed)
					report("blocks_freed", got.blocks_freed, want.blocks_freed);
			end
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	alloc_scoreboard sb = new();
	bit hold_output = 0;
	bit run_done = 0;
	// Handles currently owned by the stimulus, for well-formed frees.
	logic [9:0] owned [$];

	slab_object_allocator_unit dut (.*);

	always #1 clk = ~clk;

	task wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task write_reg(cfg_idx_t idx, logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Offers one item and waits until it is accepted; valid stays up for the next one.
	task send_item(op_t op, logic [3:0] sidx, logic [5:0] slot, bit gaps);
		in_item_t it;
		int g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			in_valid <= 0;
			wait_cycles(g);
		end
		it.operation = op;
		it.slab_index = sidx;
		it.object_slot = slot;
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		if (op == OP_ALLOC && sb.pending[$].status == ST_OK)
			owned.push_back({sb.pending[$].alloc_slab, sb.pending[$].alloc_slot});
	endtask

	task free_owned(bit gaps);
		int k;
		logic [9:0] h;
		k = $urandom_range(0, owned.size() - 1);
		h = owned[k];
		owned.delete(k);
		send_item(OP_FREE, h[9:6], h[5:0], gaps);
	endtask

	// Stops offering items and waits for the block to drain.
	task drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		wait_cycles(100);
	endtask

	task random_phase(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) send_item(OP_ALLOC, 0, 0, 1);
			else if (r < 85 && owned.size() > 0) free_owned(1);
			else if (r < 93) send_item(OP_SHRINK, 4'($urandom), 6'($urandom), 1);
			else if (r < 98) send_item(OP_FREE, 4'($urandom), 6'($urandom), 1);
			else send_item(OP_NONE, 4'($urandom), 6'($urandom), 1);
		end
	endtask

	// Output side: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		int g;
		wait (arst_n);
		forever begin
			if (hold_output) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_output = 0;
			end
			g = gap_len();
			out_stall <= (g != 0);
			repeat (g == 0 ? $urandom_range(1, 20) : g) @(posedge clk);
		end
	end

	initial begin
		wait_cycles(8);
		arst_n <= 1;
		wait_cycles(2);

		// Directed: small slabs, exhaust the limit, bad frees, shrink cases.
		write_reg(CFG_OBJS_PER_SLAB, 2);
		write_reg(CFG_SLAB_LIMIT, 2);
		write_reg(CFG_BLOCKS_PER_SLAB, 256);
		repeat (5) send_item(OP_ALLOC, 0, 0, 0);
		send_item(OP_FREE, 4'hF, 6'h3F, 0);
		send_item(OP_FREE, 0, 2, 0);
		send_item(OP_FREE, 5, 0, 0);
		send_item(OP_SHRINK, 0, 0, 0);
		while (owned.size() > 0) free_owned(0);
		send_item(OP_FREE, 0, 0, 0);
		send_item(OP_SHRINK, 0, 0, 0);
		send_item(OP_SHRINK, 0, 0, 0);
		send_item(OP_NONE, 4'hF, 6'h3F, 0);
		send_item(OP_ALLOC, 0, 0, 0);
		drain();
		write_reg(CFG_SLAB_LIMIT, 0);
		send_item(OP_ALLOC, 0, 0, 0);
		drain();
		write_reg(CFG_OBJS_PER_SLAB, 0);
		write_reg(CFG_SLAB_LIMIT, 31);
		write_reg(CFG_BLOCKS_PER_SLAB, 0);
		send_item(OP_ALLOC, 0, 0, 0);
		send_item(OP_ALLOC, 0, 0, 0);

		// Back-pressure: receiver holds while items keep coming.
		hold_output = 1;
		random_phase(20);
		drain();

		// Random phases across several register settings.
		write_reg(CFG_OBJS_PER_SLAB, 64);
		write_reg(CFG_BLOCKS_PER_SLAB, 511);
		random_phase(400);
		drain();
		write_reg(CFG_OBJS_PER_SLAB, 127);
		write_reg(CFG_SLAB_LIMIT, 16);
		random_phase(300);
		drain();
		write_reg(CFG_OBJS_PER_SLAB, 3);
		write_reg(CFG_SLAB_LIMIT, 4);
		write_reg(CFG_BLOCKS_PER_SLAB, 7);
		random_phase(500);
		drain();
		write_reg(CFG_OBJS_PER_SLAB, 1);
		write_reg(CFG_SLAB_LIMIT, 16);
		random_phase(400);
		drain();
		write_reg(CFG_OBJS_PER_SLAB, 5);
		write_reg(CFG_SLAB_LIMIT, 9);
		write_reg(CFG_BLOCKS_PER_SLAB, 100);
		random_phase(400);

		drain();
		if (sb.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
design/sor_pkg.sv
design/sor_ram.sv
design/slab_object_allocator_unit.sv
sim/slab_object_allocator_unit_tb.sv
